>>> rtl/kps_pkg.sv
`timescale 1ns / 1ps
// kps_pkg: shared types, register indexes and defaults of the keypad scanner
// no dependencies

package kps_pkg;

    // default sizes
    localparam int FIFO_DEPTH_DEF = 10;
    localparam int MAX_ROWS_DEF   = 4;
    localparam int MAX_COLS_DEF   = 4;

    // fixed field widths
    localparam int MATRIX_W = 16;
    localparam int CODE_W   = 8;
    localparam int BUF_W    = 4;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int MAP_KEYS = 16;

    // register reset values
    localparam logic [7:0] SCAN_DIVIDER_RST = 8'd25;
    localparam logic [2:0] NUM_ROWS_RST     = 3'd4;
    localparam logic [2:0] NUM_COLS_RST     = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DIVIDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_LO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_HI    = 3'd4;

    // request command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [7:0]      scan_divider;
        logic [2:0]      num_rows;
        logic [2:0]      num_cols;
        logic [127:0]    keymap;
    } t_cfg;

    // debounce state of the latched key
    typedef enum logic [1:0] {
        HOLD_IDLE,
        HOLD_WAIT,
        HOLD_CHECK
    } t_hold_state;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CODE_W-1:0] code;
    } t_fifo_req;

    typedef struct packed {
        logic             popped;
        logic             lost;
        logic [BUF_W-1:0] buffered;
    } t_fifo_status;

endpackage

>>> rtl/kps_ram.sv
`timescale 1ns / 1ps
// kps_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module kps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/kps_scan.sv
`timescale 1ns / 1ps
// kps_scan: tick divider, first-key search, debounce state machine, key map
// depends on kps_pkg

module kps_scan import kps_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_tick,
    input  logic [MATRIX_W-1:0] i_matrix,
    output logic                o_push,
    output logic [CODE_W-1:0]   o_code
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    function automatic logic is_pressed(logic [MATRIX_W-1:0] matrix, logic [6:0] bit_idx);
        logic res;
        res = 1'b0;
        if (bit_idx < 7'(MATRIX_W)) begin
            res = matrix[bit_idx[3:0]];
        end
        return res;
    endfunction

    t_hold_state   r_state, n_state;
    logic [7:0]    r_tick_count, n_tick_count;
    logic [RW-1:0] r_held_row, n_held_row;
    logic [CW-1:0] r_held_col, n_held_col;

    logic [3:0]    rows_lim, cols_lim;
    logic [7:0]    tick_inc;
    logic          scan;
    logic          found;
    logic [RW-1:0] found_row;
    logic [CW-1:0] found_col;
    logic [6:0]    held_bit;
    logic [6:0]    map_idx;
    logic          held_pressed;

    // clamp sizes to what the matrix can hold
    assign rows_lim = (int'(i_cfg.num_rows) > MAX_ROWS) ? 4'(MAX_ROWS) : 4'(i_cfg.num_rows);
    assign cols_lim = (int'(i_cfg.num_cols) > MAX_COLS) ? 4'(MAX_COLS) : 4'(i_cfg.num_cols);

    assign tick_inc = r_tick_count + 8'd1;
    assign scan     = i_tick && (tick_inc == i_cfg.scan_divider);

    // first pressed key, column by column, row by row within a column
    always_comb begin
        found     = 1'b0;
        found_row = '0;
        found_col = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                if (!found && (4'(c) < cols_lim) && (4'(r) < rows_lim)
                    && is_pressed(i_matrix, 7'(r * MAX_COLS + c))) begin
                    found     = 1'b1;
                    found_row = RW'(r);
                    found_col = CW'(c);
                end
            end
        end
    end

    assign held_bit     = 7'(r_held_row) * 7'(MAX_COLS) + 7'(r_held_col);
    assign held_pressed = is_pressed(i_matrix, held_bit);
    assign map_idx      = 7'(r_held_row) * 7'(cols_lim) + 7'(r_held_col);
    assign o_code       = (map_idx < 7'(MAP_KEYS)) ? i_cfg.keymap[map_idx[3:0] * CODE_W +: CODE_W]
                                                   : '0;

    always_comb begin
        n_state      = r_state;
        n_tick_count = r_tick_count;
        n_held_row   = r_held_row;
        n_held_col   = r_held_col;
        o_push       = 1'b0;
        if (i_tick) begin
            n_tick_count = scan ? 8'd0 : tick_inc;
        end
        if (scan) begin
            unique case (r_state)
                HOLD_IDLE: begin
                    if (found) begin
                        n_state    = HOLD_WAIT;
                        n_held_row = found_row;
                        n_held_col = found_col;
                    end
                end
                HOLD_WAIT: begin
                    n_state = HOLD_CHECK;
                end
                HOLD_CHECK: begin
                    if (!held_pressed) begin
                        n_state = HOLD_IDLE;
                        o_push  = 1'b1;
                    end
                end
                default: begin
                    n_state = HOLD_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= HOLD_IDLE;
            r_tick_count <= '0;
        end else begin
            r_state      <= n_state;
            r_tick_count <= n_tick_count;
        end
    end

    // held position is only read outside idle
    always_ff @(posedge i_clk) begin
        r_held_row <= n_held_row;
        r_held_col <= n_held_col;
    end

endmodule

>>> rtl/kps_fifo.sv
`timescale 1ns / 1ps
// kps_fifo: key code FIFO, pointers and count around one kps_ram
// depends on kps_pkg and kps_ram

module kps_fifo import kps_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_req         i_req,
    output t_fifo_status      o_status,
    output logic [CODE_W-1:0] o_rdata
);

    localparam int PW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int NW  = $clog2(FIFO_DEPTH + 1);
    localparam int NWX = (NW > BUF_W) ? NW : BUF_W;

    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [NW-1:0]  r_count, n_count;
    logic [NWX-1:0] count_ext;
    logic           full;
    logic           do_push;
    logic           do_pop;

    assign full    = (r_count == NW'(FIFO_DEPTH));
    assign do_push = i_req.push && !full;
    assign do_pop  = i_req.pop && (r_count != '0);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // push and pop come from different requests, so never share a cycle
    kps_ram #(
        .WIDTH (CODE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_req.code),
        .i_re    (do_pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (o_rdata)
    );

    assign count_ext         = NWX'(n_count);
    assign o_status.popped   = do_pop;
    assign o_status.lost     = i_req.push && full;
    assign o_status.buffered = count_ext[BUF_W-1:0];

endmodule

>>> rtl/matrix_keypad_scanner.sv
`timescale 1ns / 1ps
// Matrix keypad scanner with debounce and a buffered key FIFO.
//
// Input channel (i_in_valid / o_in_ready): each request is either a timer
// tick carrying a snapshot of the key matrix (i_command = 0) or a read of
// one buffered key (i_command = 1). Every request gives exactly one result
// on the output channel (o_out_valid / i_out_ready): key_valid and key_code
// for reads, the FIFO occupancy after the request, and key_lost when a
// released key found the FIFO full.
// Throughput is one request per cycle while the receiver keeps taking results.
// A result passes through the pending stage, which waits for the registered
// read port of the FIFO RAM, and then into the output register.
// When the receiver stalls, the pending stage still takes one more request
// and then o_in_ready drops until the output register is taken.
// Configuration goes through i_cfg_we / i_cfg_index / i_cfg_wdata, one register
// per write; the user writes only while no request is in flight (unenforced).
// Reset (synchronous, active low) restores the register defaults, empties
// the FIFO, clears the tick divider and the debounce state, and drops both
// valid flags. No clearing pass is needed, the FIFO starts usable at once.
// depends on kps_pkg, kps_scan, kps_fifo

module matrix_keypad_scanner import kps_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [MATRIX_W-1:0]  i_key_matrix,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_key_valid,
    output logic [CODE_W-1:0]    o_key_code,
    output logic [BUF_W-1:0]     o_keys_buffered,
    output logic                 o_key_lost
);

    t_cfg         r_cfg;
    t_fifo_req    fifo_req;
    t_fifo_status fifo_status;
    logic [CODE_W-1:0] ram_rdata;

    logic         accept;
    logic         scan_push;
    logic [CODE_W-1:0] scan_code;

    // pending stage: waits for the RAM read data
    logic         r_p_valid;
    t_fifo_status r_p_status;
    logic         p_adv;

    // output register
    logic              r_o_valid;
    logic              r_o_key_valid;
    logic [CODE_W-1:0] r_o_key_code;
    logic [BUF_W-1:0]  r_o_buffered;
    logic              r_o_lost;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_divider <= SCAN_DIVIDER_RST;
            r_cfg.num_rows     <= NUM_ROWS_RST;
            r_cfg.num_cols     <= NUM_COLS_RST;
            r_cfg.keymap       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCAN_DIVIDER: r_cfg.scan_divider <= i_cfg_wdata[7:0];
                CFG_NUM_ROWS:     r_cfg.num_rows     <= i_cfg_wdata[2:0];
                CFG_NUM_COLS:     r_cfg.num_cols     <= i_cfg_wdata[2:0];
                CFG_KEYMAP_LO:    r_cfg.keymap[63:0]   <= i_cfg_wdata;
                CFG_KEYMAP_HI:    r_cfg.keymap[127:64] <= i_cfg_wdata;
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    // handshake: pending stage moves when the output register is free or being taken
    assign p_adv      = r_p_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_p_valid || p_adv;
    assign accept     = i_in_valid && o_in_ready;

    kps_scan #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_tick   (accept && (i_command == CMD_TICK)),
        .i_matrix (i_key_matrix),
        .o_push   (scan_push),
        .o_code   (scan_code)
    );

    // a released key becomes a push request; a read request pops
    assign fifo_req.push = scan_push;
    assign fifo_req.pop  = accept && (i_command == CMD_READ);
    assign fifo_req.code = scan_code;

    kps_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fifo_req),
        .o_status (fifo_status),
        .o_rdata  (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_p_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status <= fifo_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // RAM data holds while the pending stage stalls, no new read is issued
    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_o_key_valid <= r_p_status.popped;
            r_o_key_code  <= r_p_status.popped ? ram_rdata : '0;
            r_o_buffered  <= r_p_status.buffered;
            r_o_lost      <= r_p_status.lost;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_key_valid     = r_o_key_valid;
    assign o_key_code      = r_o_key_code;
    assign o_keys_buffered = r_o_buffered;
    assign o_key_lost      = r_o_lost;

endmodule

>>> rtl/kps_checker.sv
`timescale 1ns / 1ps
// kps_checker: port-level assertions for matrix_keypad_scanner, with its bind
// depends on kps_pkg and matrix_keypad_scanner

module kps_checker import kps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_key_valid,
    input logic [CODE_W-1:0] o_key_code,
    input logic              o_key_lost
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // no key popped means code zero
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_key_valid |-> o_key_code == '0)
        else $error("key code set without a popped key");

    // a read never reports a lost key
    a_lost_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_key_valid && o_key_lost))
        else $error("key_valid and key_lost together");

    // reset empties the result side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_key_valid (o_key_valid),
    .o_key_code  (o_key_code),
    .o_key_lost  (o_key_lost)
);
